@@ hdl/odo_pkg.sv @@
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, scale constants and the arctangent table of the odometry
// pose integrator.
// ----------------------------------------------------------------------------
package odo_pkg;

   // register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINEAR_GAIN  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGULAR_GAIN = 8'd1;
   localparam logic [15:0] GAIN_ONE = 16'd16384;

   // fixed-point scale constants
   localparam logic [31:0] CORDIC_GAIN = 32'h9B74_EDA8;
   localparam int unsigned MUL_DIGITS  = 5;
   localparam int unsigned SCALE_W     = 8 * MUL_DIGITS;
   localparam logic [SCALE_W-1:0] POS_SCALE  = 40'd288230376152;
   localparam logic [SCALE_W-1:0] HEAD_SCALE = 40'd2867080570;

   // rotation table covers up to 28 micro-rotations
   localparam int unsigned STEP_W = 5;
   localparam int unsigned DIGIT_W = 3;

   typedef struct packed {
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
   } gain_type;

   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_GAIN,
      DP_QUAD,
      DP_ROT,
      DP_DT,
      DP_MUL,
      DP_UPDATE
   } dp_op_type;

   typedef enum logic [1:0] {
      MUL_X,
      MUL_Y,
      MUL_H
   } mul_sel_type;

   typedef struct packed {
      dp_op_type           op;
      logic [STEP_W-1:0]   step;
      logic [DIGIT_W-1:0]  digit;
      mul_sel_type         sel;
      logic                first;
      logic                last;
   } dp_cmd_type;

   // arctangent of 2^-i as a binary angle
   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'h2000_0000;
         5'd1:  val = 32'h12E4_051D;
         5'd2:  val = 32'h09FB_385B;
         5'd3:  val = 32'h0511_11D4;
         5'd4:  val = 32'h028B_0D43;
         5'd5:  val = 32'h0145_D7E1;
         5'd6:  val = 32'h00A2_F61E;
         5'd7:  val = 32'h0051_7C55;
         5'd8:  val = 32'h0028_BE53;
         5'd9:  val = 32'h0014_5F2E;
         5'd10: val = 32'h000A_2F98;
         5'd11: val = 32'h0005_17CC;
         5'd12: val = 32'h0002_8BE6;
         5'd13: val = 32'h0001_45F3;
         5'd14: val = 32'h0000_A2F9;
         5'd15: val = 32'h0000_517C;
         5'd16: val = 32'h0000_28BE;
         5'd17: val = 32'h0000_145F;
         5'd18: val = 32'h0000_0A2F;
         5'd19: val = 32'h0000_0517;
         5'd20: val = 32'h0000_028B;
         5'd21: val = 32'h0000_0145;
         5'd22: val = 32'h0000_00A2;
         5'd23: val = 32'h0000_0051;
         5'd24: val = 32'h0000_0028;
         5'd25: val = 32'h0000_0014;
         5'd26: val = 32'h0000_000A;
         5'd27: val = 32'h0000_0005;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

@@ hdl/odo_csr.sv @@
// ----------------------------------------------------------------------------
// odo_csr
// Gain registers written through the configuration port.
// ----------------------------------------------------------------------------
module odo_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [odo_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_wdata,
   output odo_pkg::gain_type                gains
);

   odo_pkg::gain_type gains_ff;

   // always able to take a write beat
   assign csr_ready = 1'b1;
   assign gains     = gains_ff;

   // register write decode, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.linear_gain  <= odo_pkg::GAIN_ONE;
         gains_ff.angular_gain <= odo_pkg::GAIN_ONE;
      end else if (csr_valid) begin
         unique case (csr_index)
            odo_pkg::CSR_LINEAR_GAIN:  gains_ff.linear_gain  <= csr_wdata;
            odo_pkg::CSR_ANGULAR_GAIN: gains_ff.angular_gain <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

@@ hdl/odo_datapath.sv @@
// ----------------------------------------------------------------------------
// odo_datapath
// Velocity scaling, quadrant fold, CORDIC rotation, serial constant multiplier
// and pose accumulators (x, y saturate, heading wraps) on controller commands.
// ----------------------------------------------------------------------------
module odo_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  odo_pkg::gain_type        gains,
   input  odo_pkg::dp_cmd_type      cmd,
   input  logic signed [15:0]       speed_forward,
   input  logic signed [15:0]       speed_side,
   input  logic signed [15:0]       yaw_rate,
   input  logic [19:0]              elapsed_us,
   output logic signed [47:0]       pos_x,
   output logic signed [47:0]       pos_y,
   output logic [31:0]              heading_angle
);

   localparam int unsigned MAC_W = 64 + odo_pkg::SCALE_W;

   // payload registers
   logic signed [31:0]  vx_ff, vy_ff, w_ff;
   logic [19:0]         dt_ff;
   logic signed [63:0]  px_ff, py_ff;
   logic signed [51:0]  wdt_ff;
   logic signed [43:0]  x_ff, y_ff;
   logic signed [31:0]  z_ff;
   logic signed [63:0]  ax_ff, ay_ff;
   logic signed [MAC_W-1:0] mac_ff;
   logic signed [27:0]  dx_ff, dy_ff;
   logic [31:0]         dh_ff;

   // pose state
   logic signed [47:0]  acc_x_ff, acc_y_ff;
   logic [31:0]         acc_h_ff;

   // next values
   logic signed [32:0]  vx_in, vy_in, w_in;
   logic signed [63:0]  px_in, py_in, ax_in, ay_in;
   logic signed [51:0]  wdt_in;
   logic signed [43:0]  xq_in, yq_in, x_rot_in, y_rot_in;
   logic signed [31:0]  zq_in, z_rot_in;
   logic signed [MAC_W-1:0] mac_in;
   logic signed [47:0]  acc_x_in, acc_y_in;
   logic [31:0]         acc_h_in;

   logic signed [16:0]  lin_s, ang_s;
   logic signed [32:0]  cg_s;
   logic signed [20:0]  dt_s;
   logic signed [43:0]  x0, y0, xs, ys;
   logic [31:0]         th_sum, atan;
   logic [1:0]          quad;
   logic signed [63:0]  mul_a;
   logic [odo_pkg::SCALE_W-1:0] mul_k;
   logic [odo_pkg::DIGIT_W-1:0] dsel;
   logic [7:0]          kd;
   logic signed [8:0]   kd_s;
   logic signed [MAC_W-1:0] prod;
   logic signed [48:0]  sum_x, sum_y;

   // input scaling and gain products
   always_comb begin
      lin_s  = $signed({1'b0, gains.linear_gain});
      ang_s  = $signed({1'b0, gains.angular_gain});
      cg_s   = $signed({1'b0, odo_pkg::CORDIC_GAIN});
      dt_s   = $signed({1'b0, dt_ff});
      vx_in  = speed_forward * lin_s;
      vy_in  = speed_side * lin_s;
      w_in   = yaw_rate * ang_s;
      px_in  = vx_ff * cg_s;
      py_in  = vy_ff * cg_s;
      wdt_in = w_ff * dt_s;
   end

   // fold heading into a quarter turn and a signed residual
   always_comb begin
      x0     = {{4{px_ff[63]}}, px_ff[63:24]};
      y0     = {{4{py_ff[63]}}, py_ff[63:24]};
      th_sum = acc_h_ff + 32'h2000_0000;
      quad   = th_sum[31:30];
      zq_in  = $signed(acc_h_ff - {quad, 30'd0});
      case (quad)
         2'd1: begin xq_in = -y0; yq_in = x0;  end
         2'd2: begin xq_in = -x0; yq_in = -y0; end
         2'd3: begin xq_in = y0;  yq_in = -x0; end
         default: begin xq_in = x0; yq_in = y0; end
      endcase
   end

   // one cordic micro-rotation
   always_comb begin
      xs   = x_ff >>> cmd.step;
      ys   = y_ff >>> cmd.step;
      atan = odo_pkg::atan_entry(cmd.step);
      if (!z_ff[31]) begin
         x_rot_in = x_ff - ys;
         y_rot_in = y_ff + xs;
         z_rot_in = z_ff - $signed(atan);
      end else begin
         x_rot_in = x_ff + ys;
         y_rot_in = y_ff - xs;
         z_rot_in = z_ff + $signed(atan);
      end
      ax_in = x_ff * dt_s;
      ay_in = y_ff * dt_s;
   end

   // serial multiply by scale constant, one byte per beat, msb first
   always_comb begin
      case (cmd.sel)
         odo_pkg::MUL_X: begin mul_a = ax_ff; mul_k = odo_pkg::POS_SCALE; end
         odo_pkg::MUL_Y: begin mul_a = ay_ff; mul_k = odo_pkg::POS_SCALE; end
         default: begin
            mul_a = {{12{wdt_ff[51]}}, wdt_ff};
            mul_k = odo_pkg::HEAD_SCALE;
         end
      endcase
      dsel   = odo_pkg::DIGIT_W'(odo_pkg::MUL_DIGITS - 1) - cmd.digit;
      kd     = 8'(mul_k >> {dsel, 3'b000});
      kd_s   = $signed({1'b0, kd});
      prod   = mul_a * kd_s;
      mac_in = (cmd.first ? '0 : (mac_ff <<< 8)) + prod;
   end

   // saturating position update and wrapping heading
   always_comb begin
      sum_x    = {acc_x_ff[47], acc_x_ff} + {{21{dx_ff[27]}}, dx_ff};
      sum_y    = {acc_y_ff[47], acc_y_ff} + {{21{dy_ff[27]}}, dy_ff};
      acc_x_in = sum_x[47:0];
      acc_y_in = sum_y[47:0];
      if (sum_x[48] != sum_x[47])
         acc_x_in = sum_x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      if (sum_y[48] != sum_y[47])
         acc_y_in = sum_y[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      acc_h_in = acc_h_ff + dh_ff;
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         odo_pkg::DP_LOAD: begin
            vx_ff <= vx_in[31:0];
            vy_ff <= vy_in[31:0];
            w_ff  <= w_in[31:0];
            dt_ff <= elapsed_us;
         end
         odo_pkg::DP_GAIN: begin
            px_ff  <= px_in;
            py_ff  <= py_in;
            wdt_ff <= wdt_in;
         end
         odo_pkg::DP_QUAD: begin
            x_ff <= xq_in;
            y_ff <= yq_in;
            z_ff <= zq_in;
         end
         odo_pkg::DP_ROT: begin
            x_ff <= x_rot_in;
            y_ff <= y_rot_in;
            z_ff <= z_rot_in;
         end
         odo_pkg::DP_DT: begin
            ax_ff <= ax_in;
            ay_ff <= ay_in;
         end
         odo_pkg::DP_MUL: begin
            mac_ff <= mac_in;
            if (cmd.last) begin
               case (cmd.sel)
                  odo_pkg::MUL_X: dx_ff <= mac_in[MAC_W-1:76];
                  odo_pkg::MUL_Y: dy_ff <= mac_in[MAC_W-1:76];
                  default:        dh_ff <= mac_in[79:48];
               endcase
            end
         end
         default: ;
      endcase
   end

   // pose accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_h_ff <= '0;
      end else if (cmd.op == odo_pkg::DP_UPDATE) begin
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         acc_h_ff <= acc_h_in;
      end
   end

   assign pos_x         = acc_x_ff;
   assign pos_y         = acc_y_ff;
   assign heading_angle = acc_h_ff;

endmodule

@@ hdl/odo_ctrl.sv @@
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer: steps the datapath through scaling, rotation and the serial
// multiplies, and owns the result beat.
// ----------------------------------------------------------------------------
module odo_ctrl #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output odo_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAIN,
      ST_QUAD,
      ST_ROT,
      ST_DT,
      ST_MUL,
      ST_UPDATE
   } state_type;

   localparam logic [odo_pkg::STEP_W-1:0] LAST_STEP =
      odo_pkg::STEP_W'(CORDIC_STEPS - 1);
   localparam logic [odo_pkg::DIGIT_W-1:0] LAST_DIGIT =
      odo_pkg::DIGIT_W'(odo_pkg::MUL_DIGITS - 1);

   state_type                    state_ff;
   logic [odo_pkg::STEP_W-1:0]   step_ff;
   logic [odo_pkg::DIGIT_W-1:0]  digit_ff;
   odo_pkg::mul_sel_type         sel_ff;
   logic                         rsp_valid_ff;
   logic                         out_free;

   assign out_free  = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd.step  = step_ff;
      cmd.digit = digit_ff;
      cmd.sel   = sel_ff;
      cmd.first = (digit_ff == '0);
      cmd.last  = (digit_ff == LAST_DIGIT);
      unique case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? odo_pkg::DP_LOAD : odo_pkg::DP_NOP;
         ST_GAIN:   cmd.op = odo_pkg::DP_GAIN;
         ST_QUAD:   cmd.op = odo_pkg::DP_QUAD;
         ST_ROT:    cmd.op = odo_pkg::DP_ROT;
         ST_DT:     cmd.op = odo_pkg::DP_DT;
         ST_MUL:    cmd.op = odo_pkg::DP_MUL;
         ST_UPDATE: cmd.op = out_free ? odo_pkg::DP_UPDATE : odo_pkg::DP_NOP;
         default:   cmd.op = odo_pkg::DP_NOP;
      endcase
   end

   // state, counters and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         digit_ff     <= '0;
         sel_ff       <= odo_pkg::MUL_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise on update, drop once the beat is taken
         if (state_ff == ST_UPDATE && out_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid)
                  state_ff <= ST_GAIN;
            end
            ST_GAIN: state_ff <= ST_QUAD;
            ST_QUAD: begin
               step_ff  <= '0;
               state_ff <= ST_ROT;
            end
            ST_ROT: begin
               if (step_ff == LAST_STEP)
                  state_ff <= ST_DT;
               else
                  step_ff <= step_ff + 1'b1;
            end
            ST_DT: begin
               digit_ff <= '0;
               sel_ff   <= odo_pkg::MUL_X;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (digit_ff == LAST_DIGIT) begin
                  digit_ff <= '0;
                  unique case (sel_ff)
                     odo_pkg::MUL_X: sel_ff <= odo_pkg::MUL_Y;
                     odo_pkg::MUL_Y: sel_ff <= odo_pkg::MUL_H;
                     default:        state_ff <= ST_UPDATE;
                  endcase
               end else begin
                  digit_ff <= digit_ff + 1'b1;
               end
            end
            ST_UPDATE: begin
               if (out_free)
                  state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

@@ hdl/odometry_pose_integrator.sv @@
// a request beat runs the sequencer through gain, quadrant fold, cordic loop,
//   time scaling, the byte-serial scale multiplies and the pose update
// a new request is taken only once the sequencer is back in idle
// a waiting result does not block the next request, only its final update
// reset: synchronous, clears pose to zero and both gains to 1.0
// ----------------------------------------------------------------------------
// odometry_pose_integrator
// Dead-reckoning pose integrator: scales body velocity, rotates it by the
// heading and integrates position and heading.
// ----------------------------------------------------------------------------
module odometry_pose_integrator #(
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_speed_forward,
   input  logic signed [15:0]               req_speed_side,
   input  logic signed [15:0]               req_yaw_rate,
   input  logic [19:0]                      req_elapsed_us,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [47:0]               rsp_pos_x,
   output logic signed [47:0]               rsp_pos_y,
   output logic [31:0]                      rsp_heading_angle,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [odo_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_wdata
);

   odo_pkg::gain_type    gains;
   odo_pkg::dp_cmd_type  cmd;

   odo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   odo_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   odo_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .gains         (gains),
      .cmd           (cmd),
      .speed_forward (req_speed_forward),
      .speed_side    (req_speed_side),
      .yaw_rate      (req_yaw_rate),
      .elapsed_us    (req_elapsed_us),
      .pos_x         (rsp_pos_x),
      .pos_y         (rsp_pos_y),
      .heading_angle (rsp_heading_angle)
   );

   // an accepted request beat makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but block not busy");

   // a new result appears only as the sequencer returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result raised while still busy");

   // heading only moves in the update beat of the sequencer
   assert property (@(posedge clock) disable iff (reset)
      cmd.op != odo_pkg::DP_UPDATE |=> $stable(rsp_heading_angle))
      else $error("heading changed outside update");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the odometry pose integrator. A directed table is
// followed by random velocity reports under several idle and stall patterns.
// Every result beat is checked against an in-bench pose predictor, or
// against the fixed pose of a typed table row.
module tb;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [47:0] x;
      logic [47:0] y;
      logic [31:0] h;
   } pose_type;

   typedef struct {
      bit          is_cfg;
      logic [7:0]  idx;
      logic [15:0] data;
      logic [15:0] sf;
      logic [15:0] ss;
      logic [15:0] wz;
      logic [19:0] dt;
      bit          typed;
      pose_type    want;
   } row_type;

   localparam int NUM_ROWS = 20;
   localparam int RAND_ITEMS = 400;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_speed_forward = '0;
   logic signed [15:0] req_speed_side = '0;
   logic signed [15:0] req_yaw_rate = '0;
   logic [19:0] req_elapsed_us = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [47:0] rsp_pos_x;
   logic signed [47:0] rsp_pos_y;
   logic [31:0] rsp_heading_angle;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [odo_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // predictor state
   logic [15:0] lin_gain;
   logic [15:0] ang_gain;
   wide_type pose_x;
   wide_type pose_y;
   logic [31:0] pose_heading;
   longint arctan_angle [28];

   pose_type pending_poses[$];
   bit typed_flags[$];
   pose_type typed_poses[$];
   row_type rows [NUM_ROWS];
   int mismatches = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_count = 0;

   always #4 clock = ~clock;

   odometry_pose_integrator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_speed_forward(req_speed_forward), .req_speed_side(req_speed_side),
      .req_yaw_rate(req_yaw_rate), .req_elapsed_us(req_elapsed_us),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_heading_angle(rsp_heading_angle),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // rotate a body vector by a binary angle: quarter turns then cordic
   function automatic void rotate_by_heading(inout longint x, inout longint y,
                                             input logic [31:0] th);
      logic [1:0] quad;
      logic signed [31:0] resid;
      longint z;
      longint t;
      longint xs;
      longint ys;
      quad = 2'((th + 32'h2000_0000) >> 30);
      resid = th - {quad, 30'd0};
      z = resid;
      case (quad)
         2'd1: begin
            t = x; x = -y; y = t;
         end
         2'd2: begin
            x = -x; y = -y;
         end
         2'd3: begin
            t = x; x = y; y = -t;
         end
         default: ;
      endcase
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - arctan_angle[i];
         end else begin
            x = x + ys; y = y - xs; z = z + arctan_angle[i];
         end
      end
   endfunction

   // advance the predicted pose by one velocity report
   function automatic pose_type integrate_report(logic signed [15:0] sf,
         logic signed [15:0] ss, logic signed [15:0] wz, logic [19:0] dt);
      wide_type a, b, c, lg, ag, kgain, kpos, khead, wdt, lim_hi, lim_lo, step;
      longint vx;
      longint vy;
      pose_type p;
      a = sf; b = ss; c = wz;
      lg = lin_gain; ag = ang_gain; wdt = dt;
      kgain = odo_pkg::CORDIC_GAIN;
      kpos = odo_pkg::POS_SCALE;
      khead = odo_pkg::HEAD_SCALE;
      lim_hi = (wide_type'(1) <<< 47) - 1;
      lim_lo = -(wide_type'(1) <<< 47);
      vx = 64'((a * lg * kgain) >>> 24);
      vy = 64'((b * lg * kgain) >>> 24);
      rotate_by_heading(vx, vy, pose_heading);
      a = vx; b = vy;
      pose_x = pose_x + ((a * wdt * kpos) >>> 76);
      pose_y = pose_y + ((b * wdt * kpos) >>> 76);
      if (pose_x > lim_hi) pose_x = lim_hi;
      if (pose_x < lim_lo) pose_x = lim_lo;
      if (pose_y > lim_hi) pose_y = lim_hi;
      if (pose_y < lim_lo) pose_y = lim_lo;
      step = (c * ag * wdt * khead) >>> 48;
      pose_heading = pose_heading + step[31:0];
      p.x = pose_x[47:0];
      p.y = pose_y[47:0];
      p.h = pose_heading;
      return p;
   endfunction

   function automatic row_type item_row(int sf, int ss, int wz, int dt);
      row_type r;
      r = '{default: '0};
      r.sf = sf[15:0]; r.ss = ss[15:0]; r.wz = wz[15:0]; r.dt = dt[19:0];
      return r;
   endfunction

   function automatic row_type cfg_row(logic [7:0] idx, logic [15:0] data);
      row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1; r.idx = idx; r.data = data;
      return r;
   endfunction

   // receiver: long hold-off on request, else random stall
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_count = 400;
      end
      if (hold_count > 0) begin
         hold_count = hold_count - 1;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // predict on request beats, check result beats
   always @(posedge clock) begin
      pose_type got;
      pose_type exp_pose;
      pose_type pred;
      if (!reset && req_valid && !req_stall) begin
         pred = integrate_report(req_speed_forward, req_speed_side, req_yaw_rate,
                                 req_elapsed_us);
         if (typed_flags.size() > 0 && typed_flags.pop_front())
            pending_poses.push_back(typed_poses.pop_front());
         else
            pending_poses.push_back(pred);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_pos_x; got.y = rsp_pos_y; got.h = rsp_heading_angle;
         if (pending_poses.size() == 0) begin
            $error("result beat with no expected pose");
            mismatches++;
         end else begin
            exp_pose = pending_poses.pop_front();
            if (got.x !== exp_pose.x) begin
               $error("pos_x expected %0h actual %0h", exp_pose.x, got.x);
               mismatches++;
            end
            if (got.y !== exp_pose.y) begin
               $error("pos_y expected %0h actual %0h", exp_pose.y, got.y);
               mismatches++;
            end
            if (got.h !== exp_pose.h) begin
               $error("heading_angle expected %0h actual %0h", exp_pose.h, got.h);
               mismatches++;
            end
         end
      end
   end

   task automatic send_report(logic [15:0] sf, logic [15:0] ss, logic [15:0] wz,
                              logic [19:0] dt);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_speed_forward = sf;
      req_speed_side = ss;
      req_yaw_rate = wz;
      req_elapsed_us = dt;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_poses.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [15:0] data);
      wait_idle();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      if (idx == odo_pkg::CSR_LINEAR_GAIN) lin_gain = data;
      else if (idx == odo_pkg::CSR_ANGULAR_GAIN) ang_gain = data;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [15:0] pick_speed();
      if ($urandom_range(1)) return 16'($urandom);
      return 16'($urandom_range(4000) - 2000);
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return odo_pkg::GAIN_ONE;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_phase(int idle, int stall, bit hold_off);
      logic [19:0] dt;
      write_reg(odo_pkg::CSR_LINEAR_GAIN, pick_gain());
      write_reg(odo_pkg::CSR_ANGULAR_GAIN, pick_gain());
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (hold_off && n == 20) hold_requests++;
         // sender pause until every pose is back
         if (n == RAND_ITEMS / 2) wait_idle();
         dt = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(20000));
         send_report(pick_speed(), pick_speed(), pick_speed(), dt);
      end
   endtask

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      pose_type zero_pose;
      arctan_angle = '{32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
         32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53,
         32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3,
         32'h0000_A2F9, 32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F,
         32'h0000_0517, 32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051,
         32'h0000_0028, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005};
      lin_gain = odo_pkg::GAIN_ONE;
      ang_gain = odo_pkg::GAIN_ONE;
      pose_x = 0;
      pose_y = 0;
      pose_heading = '0;
      zero_pose = '{x: '0, y: '0, h: '0};

      // directed table: zero time, extremes, gain extremes, zero gain, bad index
      rows[0] = item_row(0, 0, 0, 0);
      rows[0].typed = 1'b1; rows[0].want = zero_pose;
      rows[1] = item_row(32767, -32768, 32767, 0);
      rows[1].typed = 1'b1; rows[1].want = zero_pose;
      rows[2] = item_row(32767, 0, 0, 1000000);
      rows[3] = item_row(0, 32767, 0, 1048575);
      rows[4] = item_row(0, 0, 32767, 1048575);
      rows[5] = item_row(-32768, -32768, -32768, 1048575);
      rows[6] = item_row(1, -1, -1, 1);
      rows[7] = cfg_row(odo_pkg::CSR_LINEAR_GAIN, 16'hFFFF);
      rows[8] = cfg_row(odo_pkg::CSR_ANGULAR_GAIN, 16'hFFFF);
      rows[9] = item_row(32767, 32767, 32767, 1048575);
      rows[10] = item_row(-32768, 12345, -32768, 500000);
      rows[11] = cfg_row(odo_pkg::CSR_LINEAR_GAIN, 16'd0);
      rows[12] = cfg_row(odo_pkg::CSR_ANGULAR_GAIN, 16'd0);
      rows[13] = item_row(32767, 32767, 32767, 1048575);
      rows[14] = cfg_row(8'd7, 16'h1234);
      rows[15] = item_row(100, 100, 100, 1000);
      rows[16] = cfg_row(odo_pkg::CSR_LINEAR_GAIN, odo_pkg::GAIN_ONE);
      rows[17] = cfg_row(odo_pkg::CSR_ANGULAR_GAIN, odo_pkg::GAIN_ONE);
      rows[18] = item_row(0, 0, -20000, 999999);
      rows[19] = item_row(5000, -5000, 3000, 10000);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         if (rows[i].is_cfg) begin
            write_reg(rows[i].idx, rows[i].data);
         end else begin
            typed_flags.push_back(rows[i].typed);
            if (rows[i].typed) typed_poses.push_back(rows[i].want);
            send_report(rows[i].sf, rows[i].ss, rows[i].wz, rows[i].dt);
         end
      end

      random_phase(0, 0, 1'b1);
      random_phase(68, 0, 1'b0);
      random_phase(0, 68, 1'b0);
      random_phase(6, 6, 1'b1);

      wait_idle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
